// ===== design/lgm_pkg.sv =====
// Package for the lidar occupancy grid marker.
// Holds the configuration struct, the queue entry type, register indexes and the CORDIC table.
// No dependencies.
package lgm_pkg;

    localparam int CORDIC_STEPS = 14;
    localparam int CORDIC_GAIN_Q15 = 19898;
    localparam int IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [IDX_W-1:0] REG_RANGE_LIMIT = 3'd0;
    localparam logic [IDX_W-1:0] REG_EXTENSION = 3'd1;
    localparam logic [IDX_W-1:0] REG_STEP = 3'd2;
    localparam logic [IDX_W-1:0] REG_GRID_OFFSET = 3'd3;
    localparam logic [IDX_W-1:0] REG_CELLS_PER_M = 3'd4;
    localparam logic [IDX_W-1:0] REG_START_ANGLE = 3'd5;
    localparam logic [IDX_W-1:0] REG_ANGLE_STEP = 3'd6;

    typedef struct packed {
        logic [15:0] range_limit;
        logic [11:0] extension_length;
        logic [9:0]  step_length;
        logic [15:0] grid_offset;
        logic [15:0] cells_per_meter;
        logic [15:0] start_angle;
        logic [11:0] angle_step;
    } cfg_t;

    typedef struct packed {
        logic [15:0] range;
        logic        hit;
        logic        last;
        logic [15:0] angle;
    } beam_t;

    function automatic logic signed [16:0] atan_entry(input logic [3:0] i);
        logic signed [16:0] v;
        begin
            unique case (i)
                4'd0: v = 17'sd8192;
                4'd1: v = 17'sd4836;
                4'd2: v = 17'sd2555;
                4'd3: v = 17'sd1297;
                4'd4: v = 17'sd651;
                4'd5: v = 17'sd326;
                4'd6: v = 17'sd163;
                4'd7: v = 17'sd81;
                4'd8: v = 17'sd41;
                4'd9: v = 17'sd20;
                4'd10: v = 17'sd10;
                4'd11: v = 17'sd5;
                4'd12: v = 17'sd3;
                4'd13: v = 17'sd1;
                default: v = 17'sd0;
            endcase
            return v;
        end
    endfunction

endpackage

// ===== design/lgm_front.sv =====
// Front end: accepts beams, checks the range limit and computes the beam angle.
// Depends on lgm_pkg.
module lgm_front
    import lgm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] beam_range,
    input  logic        last_beam,
    input  logic        q_full,
    output logic        q_push,
    output beam_t       q_data
);

    logic [15:0] count_reg;
    logic [15:0] count_next;
    logic [27:0] angle_prod;

    assign in_stall = q_full;
    assign q_push = in_valid && !q_full;
    assign angle_prod = count_reg * cfg.angle_step;

    always_comb
    begin
        q_data.range = beam_range;
        q_data.hit = beam_range < cfg.range_limit;
        q_data.last = last_beam;
        q_data.angle = cfg.start_angle + angle_prod[15:0];
        count_next = count_reg;
        if (q_push)
        begin
            count_next = last_beam ? 16'd0 : count_reg + 16'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 16'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

// ===== design/lgm_queue.sv =====
// Two-entry queue of beams between the front end and the marking engine.
// Depends on lgm_pkg.
module lgm_queue
    import lgm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  beam_t push_data,
    input  logic  pop,
    output beam_t pop_data,
    output logic  full,
    output logic  empty
);

    beam_t       entry_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;

    assign full = count_reg == 2'd2;
    assign empty = count_reg == 2'd0;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// ===== design/lgm_back.sv =====
// Marking engine: CORDIC, ray point mapping, grid memory and row readout.
// Depends on lgm_pkg.
module lgm_back
    import lgm_pkg::*;
#(
    parameter int GRID_CELLS = 50,
    parameter int ROW_W = 6
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  logic                  q_empty,
    input  beam_t                 q_data,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [ROW_W-1:0]      row_number,
    output logic [GRID_CELLS-1:0] row_cells,
    output logic                  last_row
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ROT = 4'd1;
    localparam logic [3:0] S_MUL1 = 4'd2;
    localparam logic [3:0] S_MUL2 = 4'd3;
    localparam logic [3:0] S_IDX = 4'd4;
    localparam logic [3:0] S_RD = 4'd5;
    localparam logic [3:0] S_WR = 4'd6;
    localparam logic [3:0] S_RO_RD = 4'd7;
    localparam logic [3:0] S_RO_OUT = 4'd8;
    localparam logic [ROW_W-1:0] LAST_IDX = ROW_W'(GRID_CELLS - 1);

    logic [3:0]  state_reg;
    logic [3:0]  iter_reg;
    logic        flip_reg;
    logic        last_reg;
    logic [15:0] range_reg;
    logic signed [17:0] x_reg;
    logic signed [17:0] y_reg;
    logic signed [16:0] z_reg;
    logic signed [17:0] cos_reg;
    logic signed [17:0] sin_reg;
    logic [12:0] step_pos_reg;
    logic [16:0] dist_reg;
    logic signed [35:0] prod_r_reg;
    logic signed [35:0] prod_c_reg;
    logic signed [53:0] n_r_reg;
    logic signed [53:0] n_c_reg;
    logic [ROW_W-1:0] row_idx_reg;
    logic [ROW_W-1:0] col_idx_reg;
    logic        point_ok_reg;
    logic [ROW_W-1:0] ro_row_reg;
    logic [GRID_CELLS-1:0] rd_data_reg;
    logic [GRID_CELLS-1:0] row_valid_reg;
    logic [GRID_CELLS-1:0] grid_mem [GRID_CELLS];
    logic        out_valid_reg;
    logic [ROW_W-1:0] out_row_reg;
    logic [GRID_CELLS-1:0] out_cells_reg;
    logic        out_last_reg;

    logic [15:0] angle_plus;
    logic        flip_in;
    logic [15:0] angle_red;
    logic signed [17:0] dx;
    logic signed [17:0] dy;
    logic signed [17:0] x_next;
    logic signed [17:0] y_next;
    logic signed [16:0] atan_val;
    logic signed [36:0] off_sum_r;
    logic signed [36:0] off_sum_c;
    logic signed [36:0] off_shift;
    logic signed [16:0] cpm_s;
    logic [53:0] mag_r;
    logic [53:0] mag_c;
    logic [20:0] m_r;
    logic [20:0] m_c;
    logic        ok_r;
    logic        ok_c;
    logic [12:0] step_pos_next;
    logic [16:0] dist_next;
    logic        ray_done;
    logic        out_free;

    assign out_valid = out_valid_reg;
    assign row_number = out_row_reg;
    assign row_cells = out_cells_reg;
    assign last_row = out_last_reg;
    assign out_free = !out_valid_reg || !out_stall;
    assign q_pop = (state_reg == S_IDLE) && !q_empty;

    always_comb
    begin
        angle_plus = q_data.angle + 16'd16384;
        flip_in = angle_plus[15];
        angle_red = flip_in ? (q_data.angle ^ 16'h8000) : q_data.angle;
        dx = y_reg >>> iter_reg;
        dy = x_reg >>> iter_reg;
        atan_val = atan_entry(iter_reg);
        if (z_reg >= 0)
        begin
            x_next = x_reg - dx;
            y_next = y_reg + dy;
        end
        else
        begin
            x_next = x_reg + dx;
            y_next = y_reg - dy;
        end
        off_shift = $signed({6'd0, cfg.grid_offset, 15'd0});
        off_sum_r = 37'(prod_r_reg) + off_shift;
        off_sum_c = 37'(prod_c_reg) + off_shift;
        cpm_s = $signed({1'b0, cfg.cells_per_meter});
        mag_r = n_r_reg[53] ? 54'(-n_r_reg) : 54'(n_r_reg);
        mag_c = n_c_reg[53] ? 54'(-n_c_reg) : 54'(n_c_reg);
        m_r = 21'((mag_r + 54'h1_0000_0000) >> 33);
        m_c = 21'((mag_c + 54'h1_0000_0000) >> 33);
        ok_r = n_r_reg[53] ? (m_r == 21'd0) : (m_r < 21'(GRID_CELLS));
        ok_c = n_c_reg[53] ? (m_c == 21'd0) : (m_c < 21'(GRID_CELLS));
        step_pos_next = step_pos_reg + 13'(cfg.step_length);
        dist_next = 17'(range_reg) + 17'(step_pos_next);
        ray_done = (cfg.step_length == 10'd0) || (step_pos_next >= 13'(cfg.extension_length))
                   || (dist_next > 17'(cfg.range_limit));
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_RD)
        begin
            rd_data_reg <= row_valid_reg[row_idx_reg] ? grid_mem[row_idx_reg] : '0;
        end
        else if (state_reg == S_RO_RD)
        begin
            rd_data_reg <= row_valid_reg[ro_row_reg] ? grid_mem[ro_row_reg] : '0;
        end
        if (state_reg == S_WR && point_ok_reg)
        begin
            grid_mem[row_idx_reg] <= rd_data_reg | (GRID_CELLS'(1) << col_idx_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                range_reg <= q_data.range;
                last_reg <= q_data.last;
                flip_reg <= flip_in;
                x_reg <= 18'(CORDIC_GAIN_Q15);
                y_reg <= 18'sd0;
                z_reg <= 17'(signed'(angle_red));
                iter_reg <= 4'd0;
            end
            S_ROT:
            begin
                x_reg <= x_next;
                y_reg <= y_next;
                z_reg <= (z_reg >= 0) ? z_reg - atan_val : z_reg + atan_val;
                iter_reg <= iter_reg + 4'd1;
                cos_reg <= flip_reg ? -x_next : x_next;
                sin_reg <= flip_reg ? -y_next : y_next;
                step_pos_reg <= 13'd0;
                dist_reg <= 17'(range_reg);
            end
            S_MUL1:
            begin
                prod_r_reg <= $signed({1'b0, dist_reg}) * cos_reg;
                prod_c_reg <= $signed({1'b0, dist_reg}) * sin_reg;
            end
            S_MUL2:
            begin
                n_r_reg <= 54'(off_sum_r * cpm_s);
                n_c_reg <= 54'(off_sum_c * cpm_s);
            end
            S_IDX:
            begin
                row_idx_reg <= m_r[ROW_W-1:0];
                col_idx_reg <= m_c[ROW_W-1:0];
                point_ok_reg <= ok_r && ok_c;
            end
            S_WR:
            begin
                step_pos_reg <= step_pos_next;
                dist_reg <= dist_next;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ro_row_reg <= '0;
            row_valid_reg <= '0;
            out_valid_reg <= 1'b0;
            out_row_reg <= '0;
            out_cells_reg <= '0;
            out_last_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && state_reg != S_RO_OUT)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        if (q_data.hit)
                        begin
                            state_reg <= S_ROT;
                        end
                        else if (q_data.last)
                        begin
                            ro_row_reg <= '0;
                            state_reg <= S_RO_RD;
                        end
                    end
                end
                S_ROT:
                begin
                    if (iter_reg == 4'(CORDIC_STEPS - 1))
                    begin
                        if (cfg.extension_length != 12'd0)
                        begin
                            state_reg <= S_MUL1;
                        end
                        else if (last_reg)
                        begin
                            ro_row_reg <= '0;
                            state_reg <= S_RO_RD;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_MUL1:
                begin
                    state_reg <= S_MUL2;
                end
                S_MUL2:
                begin
                    state_reg <= S_IDX;
                end
                S_IDX:
                begin
                    if (ok_r && ok_c)
                    begin
                        state_reg <= S_RD;
                    end
                    else
                    begin
                        state_reg <= S_WR;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_WR;
                end
                S_WR:
                begin
                    if (point_ok_reg)
                    begin
                        row_valid_reg[row_idx_reg] <= 1'b1;
                    end
                    if (!ray_done)
                    begin
                        state_reg <= S_MUL1;
                    end
                    else if (last_reg)
                    begin
                        ro_row_reg <= '0;
                        state_reg <= S_RO_RD;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_RO_RD:
                begin
                    row_valid_reg[ro_row_reg] <= 1'b0;
                    state_reg <= S_RO_OUT;
                end
                S_RO_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_row_reg <= ro_row_reg;
                        out_cells_reg <= rd_data_reg;
                        out_last_reg <= ro_row_reg == LAST_IDX;
                        if (ro_row_reg == LAST_IDX)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            ro_row_reg <= ro_row_reg + ROW_W'(1);
                            state_reg <= S_RO_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== design/lidar_occupancy_grid_marker.sv =====
// Top level of the lidar occupancy grid marker: configuration registers, front end, queue, engine.
// Depends on lgm_pkg, lgm_front, lgm_queue and lgm_back.
//
//   Channel   Direction  Handshake          Beat payload
//   beams     in         in_valid/in_stall  beam_range, last_beam
//   rows      out        out_valid/out_stall row_number, row_cells, last_row
//   config    in         cfg_we             cfg_index, cfg_data
//
// A beam starts in the idle state, then runs the CORDIC rotation steps and, for each
// ray point, the states MUL1, MUL2, IDX, RD and WR (RD is skipped for a point that
// falls off the grid); the grid memory is read in RD and written in WR.
// After a scan's last beam each row is read in RO_RD, then sent in RO_OUT when the output is free.
// Reset clears the grid through per-row valid bits; no sweep is run.
// Two beams can wait in the queue while the engine works or the output stalls.
module lidar_occupancy_grid_marker
    import lgm_pkg::*;
#(
    parameter int GRID_CELLS = 50
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [15:0]                   beam_range,
    input  logic                          last_beam,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [$clog2(GRID_CELLS)-1:0] row_number,
    output logic [GRID_CELLS-1:0]         row_cells,
    output logic                          last_row,
    input  logic                          cfg_we,
    input  logic [IDX_W-1:0]              cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data
);

    localparam int ROW_W = $clog2(GRID_CELLS);

    cfg_t  cfg_reg;
    logic  q_push;
    logic  q_pop;
    logic  q_full;
    logic  q_empty;
    beam_t q_in;
    beam_t q_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.range_limit <= 16'd4096;
            cfg_reg.extension_length <= 12'd512;
            cfg_reg.step_length <= 10'd51;
            cfg_reg.grid_offset <= 16'd4096;
            cfg_reg.cells_per_meter <= 16'd1600;
            cfg_reg.start_angle <= 16'h8000;
            cfg_reg.angle_step <= 12'd182;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RANGE_LIMIT: cfg_reg.range_limit <= cfg_data;
                REG_EXTENSION: cfg_reg.extension_length <= cfg_data[11:0];
                REG_STEP: cfg_reg.step_length <= cfg_data[9:0];
                REG_GRID_OFFSET: cfg_reg.grid_offset <= cfg_data;
                REG_CELLS_PER_M: cfg_reg.cells_per_meter <= cfg_data;
                REG_START_ANGLE: cfg_reg.start_angle <= cfg_data;
                REG_ANGLE_STEP: cfg_reg.angle_step <= cfg_data[11:0];
                default:
                begin
                end
            endcase
        end
    end

    lgm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .beam_range (beam_range),
        .last_beam  (last_beam),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_in)
    );

    lgm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .full      (q_full),
        .empty     (q_empty)
    );

    lgm_back #(
        .GRID_CELLS (GRID_CELLS),
        .ROW_W      (ROW_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_empty    (q_empty),
        .q_data     (q_out),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .row_number (row_number),
        .row_cells  (row_cells),
        .last_row   (last_row)
    );

endmodule

// ===== design/lgm_checker.sv =====
// Port checker for the lidar occupancy grid marker, bound to the top level.
// Depends on lidar_occupancy_grid_marker.
module lgm_checker #(
    parameter int GRID_CELLS = 50
)
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [$clog2(GRID_CELLS)-1:0] row_number,
    input logic                          last_row
);

    localparam int ROW_W = $clog2(GRID_CELLS);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(row_number))
        else $error("Stalled row beat changed.");

    a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_row == (row_number == ROW_W'(GRID_CELLS - 1))))
        else $error("Last row flag does not match the row number.");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> row_number < ROW_W'(GRID_CELLS - 1) || row_number == ROW_W'(GRID_CELLS - 1))
        else $error("Row number is off the grid.");

endmodule

bind lidar_occupancy_grid_marker lgm_checker #(
    .GRID_CELLS (GRID_CELLS)
) u_lgm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .row_number (row_number),
    .last_row   (last_row)
);

// ===== sim/lidar_occupancy_grid_marker_tb.sv =====
// Testbench for lidar_occupancy_grid_marker: drives lidar scans with random gaps and
// stalls and checks every grid row read out against an in-bench prediction.
// Depends on lgm_pkg and the lidar_occupancy_grid_marker RTL.
`timescale 1ns / 100ps

module lidar_occupancy_grid_marker_tb;
    import lgm_pkg::*;

    localparam int GRID = 50;
    localparam int RW = $clog2(GRID);
    localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct {
        logic [15:0] range;
        logic        last;
    } beam_item_t;

    typedef struct {
        logic [RW-1:0]   row;
        logic [GRID-1:0] cells;
        logic            last;
    } grid_row_t;

    logic            clk;
    logic            rst_n;
    logic            in_valid;
    logic            in_stall;
    logic [15:0]     beam_range;
    logic            last_beam;
    logic            out_valid;
    logic            out_stall;
    logic [RW-1:0]   row_number;
    logic [GRID-1:0] row_cells;
    logic            last_row;
    logic            cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    beam_item_t pending_beams[$];
    grid_row_t  rows_due[$];
    logic [GRID-1:0] shadow_grid[GRID];
    logic [15:0] scan_beam_count;
    cfg_t        shadow_cfg;
    int          errors;
    int          rows_seen;
    int          beams_sent;
    int          in_gap;
    int          out_gap;
    bit          in_burst;
    bit          out_burst;
    int          arctan_q15[CORDIC_STEPS] = '{8192, 4836, 2555, 1297, 651, 326, 163,
                                              81, 41, 20, 10, 5, 3, 1};

    lidar_occupancy_grid_marker #(.GRID_CELLS(GRID)) uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .beam_range(beam_range), .last_beam(last_beam),
        .out_valid(out_valid), .out_stall(out_stall),
        .row_number(row_number), .row_cells(row_cells), .last_row(last_row),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void beam_direction(input logic [15:0] ang, output int c, output int s);
        logic [15:0] a;
        logic [15:0] t;
        bit flip;
        int x;
        int y;
        int z;
        int dx;
        int dy;
        t = ang + 16'd16384;
        flip = t[15];
        a = flip ? ang - 16'd32768 : ang;
        z = int'($signed(a));
        x = CORDIC_GAIN_Q15;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - arctan_q15[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + arctan_q15[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint grid_index(input int d, input int trig);
        longint n;
        longint half;
        half = longint'(1) << 32;
        n = (longint'(d) * trig + (longint'(shadow_cfg.grid_offset) << 15))
            * longint'(shadow_cfg.cells_per_meter);
        if (n >= 0)
            return (n + half) >>> 33;
        return -((-n + half) >>> 33);
    endfunction

    task automatic mark_beam(input logic [15:0] range, input logic last);
        logic [15:0] ang;
        int c;
        int s;
        int d;
        longint r;
        longint k;
        grid_row_t g;
        if (range < shadow_cfg.range_limit)
        begin
            ang = shadow_cfg.start_angle + scan_beam_count * 16'(shadow_cfg.angle_step);
            beam_direction(ang, c, s);
            for (int j = 0; j < shadow_cfg.extension_length; j += shadow_cfg.step_length)
            begin
                d = range + j;
                if (d > shadow_cfg.range_limit)
                    break;
                r = grid_index(d, c);
                k = grid_index(d, s);
                if (r >= 0 && r < GRID && k >= 0 && k < GRID)
                    shadow_grid[r][k] = 1'b1;
                if (shadow_cfg.step_length == 0)
                    break;
            end
        end
        scan_beam_count = scan_beam_count + 16'd1;
        if (last)
        begin
            for (int i = 0; i < GRID; i++)
            begin
                g.row = RW'(i);
                g.cells = shadow_grid[i];
                g.last = (i == GRID - 1);
                rows_due = {rows_due, g};
                shadow_grid[i] = '0;
            end
            scan_beam_count = '0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        beam_item_t b;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            beam_range <= '0;
            last_beam <= 1'b0;
            in_gap <= 0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_gap > 0)
            begin
                in_gap <= in_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_beams.size() > 0)
            begin
                b = pending_beams.pop_front();
                in_valid <= 1'b1;
                beam_range <= b.range;
                last_beam <= b.last;
                in_gap <= in_burst ? 0 : $urandom_range(0, 19);
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            mark_beam(beam_range, last_beam);
            beams_sent++;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_gap <= 0;
        end
        else if (out_gap > 0)
        begin
            out_stall <= 1'b1;
            out_gap <= out_gap - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            if (out_valid && !out_stall)
                out_gap <= out_burst ? 0 : $urandom_range(0, 19);
        end
    end

    always @(posedge clk)
    begin
        grid_row_t g;
        if (rst_n && out_valid && !out_stall)
        begin
            rows_seen++;
            if (rows_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected row beat: row %0d cells %h last %b",
                         $time, row_number, row_cells, last_row);
            end
            else
            begin
                g = rows_due.pop_front();
                if (row_number !== g.row)
                begin
                    errors++;
                    $display("%0t: row_number expected %0d actual %0d", $time, g.row, row_number);
                end
                if (row_cells !== g.cells)
                begin
                    errors++;
                    $display("%0t: row %0d row_cells expected %h actual %h",
                             $time, g.row, g.cells, row_cells);
                end
                if (last_row !== g.last)
                begin
                    errors++;
                    $display("%0t: row %0d last_row expected %b actual %b",
                             $time, g.row, g.last, last_row);
                end
            end
        end
    end

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [15:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            REG_RANGE_LIMIT: shadow_cfg.range_limit = value;
            REG_EXTENSION: shadow_cfg.extension_length = value[11:0];
            REG_STEP: shadow_cfg.step_length = value[9:0];
            REG_GRID_OFFSET: shadow_cfg.grid_offset = value;
            REG_CELLS_PER_M: shadow_cfg.cells_per_meter = value;
            REG_START_ANGLE: shadow_cfg.start_angle = value;
            REG_ANGLE_STEP: shadow_cfg.angle_step = value[11:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_all(input logic [15:0] lim, input logic [15:0] ext, input logic [15:0] stp,
                           input logic [15:0] off, input logic [15:0] cpm,
                           input logic [15:0] ang0, input logic [15:0] dang);
        write_reg(REG_RANGE_LIMIT, lim);
        write_reg(REG_EXTENSION, ext);
        write_reg(REG_STEP, stp);
        write_reg(REG_GRID_OFFSET, off);
        write_reg(REG_CELLS_PER_M, cpm);
        write_reg(REG_START_ANGLE, ang0);
        write_reg(REG_ANGLE_STEP, dang);
    endtask

    task automatic push_beam(input logic [15:0] r, input logic l);
        beam_item_t b;
        b.range = r;
        b.last = l;
        pending_beams = {pending_beams, b};
    endtask

    task automatic random_scan(input int n);
        logic [15:0] r;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 4) == 0 || shadow_cfg.range_limit == 0)
                r = 16'($urandom_range(0, 65535));
            else
                r = 16'($urandom_range(0, shadow_cfg.range_limit - 1));
            push_beam(r, i == n - 1);
        end
    endtask

    task automatic settle();
        while (pending_beams.size() != 0 || in_valid || rows_due.size() != 0)
        begin
            @(posedge clk);
            #1;
        end
        repeat (20) @(posedge clk);
        in_burst = $urandom_range(0, 2) == 0;
        out_burst = $urandom_range(0, 2) == 0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        rows_seen = 0;
        beams_sent = 0;
        in_burst = 1'b0;
        out_burst = 1'b0;
        scan_beam_count = '0;
        foreach (shadow_grid[i])
            shadow_grid[i] = '0;
        shadow_cfg = '{range_limit: 16'd4096, extension_length: 12'd512, step_length: 10'd51,
                       grid_offset: 16'd4096, cells_per_meter: 16'd1600,
                       start_angle: 16'h8000, angle_step: 12'd182};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_beam(16'd0, 1'b0);
        push_beam(16'd4095, 1'b0);
        push_beam(16'd4096, 1'b0);
        push_beam(16'hFFFF, 1'b0);
        push_beam(16'd2048, 1'b1);
        settle();

        set_all(16'd4096, 16'd0, 16'd51, 16'd4096, 16'd1600, 16'd0, 16'd1000);
        push_beam(16'd1000, 1'b0);
        push_beam(16'd2000, 1'b1);
        settle();

        write_reg(REG_EXTENSION, 16'hF100);
        write_reg(REG_STEP, 16'hFC00);
        push_beam(16'd1500, 1'b0);
        push_beam(16'd3000, 1'b1);
        settle();

        set_all(16'd8000, 16'd300, 16'd37, 16'd4096, 16'd0, 16'h7FFF, 16'd4095);
        write_reg(REG_UNUSED, 16'hFFFF);
        push_beam(16'd100, 1'b0);
        push_beam(16'd7999, 1'b1);
        settle();

        set_all(16'hFFFF, 16'd4095, 16'd1023, 16'd0, 16'hFFFF, 16'h8000, 16'd4095);
        push_beam(16'd10, 1'b0);
        push_beam(16'hFFFE, 1'b0);
        push_beam(16'd300, 1'b1);
        settle();

        set_all(16'd0, 16'd512, 16'd1, 16'hFFFF, 16'd1600, 16'd0, 16'd0);
        push_beam(16'd0, 1'b0);
        push_beam(16'h5555, 1'b1);
        settle();

        set_all(16'd4096, 16'd40, 16'd1, 16'd4096, 16'd1600, 16'h8000, 16'd182);
        random_scan(4);
        settle();

        for (int p = 0; p < 11; p++)
        begin
            set_all(16'($urandom_range(1000, 8000)), 16'($urandom_range(0, 1500)),
                    16'($urandom_range(40, 300)), 16'($urandom_range(2000, 8000)),
                    16'($urandom_range(200, 3000)), 16'($urandom_range(0, 65535)),
                    16'($urandom_range(0, 4095)));
            random_scan($urandom_range(6, 14));
            settle();
        end

        repeat (50) @(posedge clk);
        $display("Sent %0d beams over 18 register settings; checked %0d grid rows.",
                 beams_sent, rows_seen);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Timeout with %0d rows still expected.", rows_due.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
